/* rtl/hsc_pkg.sv */
// ----------------------------------------------------------------------------
// hsc_pkg: shared types and codes of the HSMS session control block
// Beat types of both channels, configuration and session state records, and
// the command, action, session type and status codes.
// ----------------------------------------------------------------------------
package hsc_pkg;

	// Commands of an input beat
	localparam logic [2:0] CMD_HEADER    = 3'd0;
	localparam logic [2:0] CMD_CONNECTED = 3'd1;
	localparam logic [2:0] CMD_TIMEOUT   = 3'd2;
	localparam logic [2:0] CMD_TICK      = 3'd3;
	localparam logic [2:0] CMD_CLOSED    = 3'd4;

	// Actions of a result beat
	localparam logic [2:0] ACT_NONE      = 3'd0;
	localparam logic [2:0] ACT_SEND      = 3'd1;
	localparam logic [2:0] ACT_DELIVER   = 3'd2;
	localparam logic [2:0] ACT_CLOSE     = 3'd3;
	localparam logic [2:0] ACT_NOTIFY    = 3'd4;
	localparam logic [2:0] ACT_RETIRE    = 3'd5;
	localparam logic [2:0] ACT_FRAME_ERR = 3'd6;

	// Session types
	localparam logic [7:0] ST_DATA       = 8'd0;
	localparam logic [7:0] ST_SELECT_REQ = 8'd1;
	localparam logic [7:0] ST_SELECT_RSP = 8'd2;
	localparam logic [7:0] ST_DESEL_REQ  = 8'd3;
	localparam logic [7:0] ST_DESEL_RSP  = 8'd4;
	localparam logic [7:0] ST_LINK_REQ   = 8'd5;
	localparam logic [7:0] ST_LINK_RSP   = 8'd6;
	localparam logic [7:0] ST_REJECT     = 8'd7;
	localparam logic [7:0] ST_SEPARATE   = 8'd9;

	// Status and reason codes
	localparam logic [7:0] STAT_OK             = 8'd0;
	localparam logic [7:0] STAT_ACTIVE         = 8'd1;
	localparam logic [7:0] STAT_NOT_READY      = 8'd2;
	localparam logic [7:0] STAT_NOT_ESTAB      = 8'd1;
	localparam logic [7:0] RSN_STYPE           = 8'd1;
	localparam logic [7:0] RSN_PTYPE           = 8'd2;
	localparam logic [7:0] RSN_NOT_SELECTED    = 8'd4;

	// Link states
	localparam logic [1:0] LINK_DOWN         = 2'd0;
	localparam logic [1:0] LINK_NOT_SELECTED = 2'd1;
	localparam logic [1:0] LINK_SELECTED     = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_DEVICE_ID  = 3'd0;
	localparam logic [2:0] REG_ACTIVE     = 3'd1;
	localparam logic [2:0] REG_GATEWAY    = 3'd2;
	localparam logic [2:0] REG_GS         = 3'd3;
	localparam logic [2:0] REG_T7_LIMIT   = 3'd4;
	localparam logic [2:0] REG_T8_PERIOD  = 3'd5;
	localparam logic [2:0] REG_LINK_CHECK = 3'd6;

	localparam logic [15:0] ALL_SESSIONS   = 16'hFFFF;
	localparam logic [31:0] MIN_BLOCK_LEN  = 32'd10;
	localparam logic [17:0] T7_RESET       = 18'd10000;
	localparam logic [16:0] T8_RESET       = 17'd5000;
	localparam logic [17:0] LINK_CHECK_RST = 18'd30000;

	localparam int CFG_DATA_W = 18;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] block_length;
		logic [15:0] session_id;
		logic [7:0]  header_byte2;
		logic [7:0]  header_byte3;
		logic [7:0]  ptype;
		logic [7:0]  stype;
		logic [31:0] system_bytes;
	} item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] out_session_id;
		logic [7:0]  out_byte2;
		logic [7:0]  out_status;
		logic [7:0]  out_stype;
		logic [31:0] out_system_bytes;
		logic [1:0]  session_state;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [15:0] device_id;
		logic        active_mode;
		logic        gateway_mode;
		logic        gs_mode;
		logic [17:0] t7_limit_ms;
		logic [16:0] t8_period_ms;
		logic [17:0] link_check_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  link_state;
		logic        t7_running;
		logic [17:0] t7_remaining;
		logic [17:0] idle_time;
		logic [1:0]  missed_linktests;
	} sess_t;

	// Up to two results produced by one event.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} pair_t;

	function automatic result_t make_res(logic [2:0] act, logic [15:0] sid,
			logic [7:0] b2, logic [7:0] st, logic [7:0] sty, logic [31:0] sys);
		result_t r;
		r.action           = act;
		r.out_session_id   = sid;
		r.out_byte2        = b2;
		r.out_status       = st;
		r.out_stype        = sty;
		r.out_system_bytes = sys;
		r.session_state    = LINK_DOWN;
		r.last             = 1'b0;
		return r;
	endfunction

endpackage

/* rtl/hsc_step.sv */
// ----------------------------------------------------------------------------
// hsc_step: session state transition for one event
// Computes the next session record and the one or two result beats that the
// registered event causes.
// ----------------------------------------------------------------------------
module hsc_step (
	input  hsc_pkg::item_t item,
	input  hsc_pkg::sess_t cur,
	input  hsc_pkg::cfg_t  cfg,
	output hsc_pkg::sess_t nxt,
	output hsc_pkg::pair_t pair
);

	logic [18:0]      idle_sum;
	logic [17:0]      idle_sat;
	logic [7:0]       bad_type;
	logic [7:0]       sel_status;
	hsc_pkg::result_t r0;
	hsc_pkg::result_t r1;
	logic [1:0]       n;
	hsc_pkg::result_t rej_res;

	always_comb begin
		idle_sum = {1'b0, cur.idle_time} + {2'b00, cfg.t8_period_ms};
		idle_sat = (idle_sum > {1'b0, cfg.link_check_ms}) ? cfg.link_check_ms
			: idle_sum[17:0];
		bad_type = (item.ptype != 8'd0) ? item.ptype : item.stype;
		sel_status = (cfg.gs_mode && (item.session_id != cfg.device_id))
			? hsc_pkg::STAT_NOT_READY : hsc_pkg::STAT_ACTIVE;
		rej_res = hsc_pkg::make_res(hsc_pkg::ACT_SEND, item.session_id, bad_type,
			hsc_pkg::RSN_STYPE, hsc_pkg::ST_REJECT, item.system_bytes);
	end

	always_comb begin
		nxt = cur;
		r0  = '0;
		r1  = '0;
		n   = 2'd0;
		case (item.command)
			hsc_pkg::CMD_HEADER: begin
				nxt.idle_time = '0;
				if (item.block_length < hsc_pkg::MIN_BLOCK_LEN) begin
					r0 = hsc_pkg::make_res(hsc_pkg::ACT_FRAME_ERR, '0, '0, '0, '0, '0);
					n  = 2'd1;
				end else if (item.ptype != 8'd0) begin
					r0 = rej_res;
					r0.out_status = hsc_pkg::RSN_PTYPE;
					n  = 2'd1;
				end else begin
					case (item.stype)
						hsc_pkg::ST_DATA: begin
							if (cur.link_state == hsc_pkg::LINK_SELECTED) begin
								r0 = hsc_pkg::make_res(hsc_pkg::ACT_DELIVER, item.session_id,
									item.header_byte2, item.header_byte3, '0,
									item.system_bytes);
							end else begin
								r0 = rej_res;
								r0.out_status = hsc_pkg::RSN_NOT_SELECTED;
							end
							n = 2'd1;
						end
						hsc_pkg::ST_SELECT_REQ: begin
							r0 = hsc_pkg::make_res(hsc_pkg::ACT_SEND, item.session_id, '0,
								hsc_pkg::STAT_OK, hsc_pkg::ST_SELECT_RSP, item.system_bytes);
							n  = 2'd1;
							if (cur.link_state == hsc_pkg::LINK_NOT_SELECTED) begin
								nxt.link_state = hsc_pkg::LINK_SELECTED;
								nxt.t7_running = 1'b0;
								r1 = hsc_pkg::make_res(hsc_pkg::ACT_NOTIFY, '0, '0, '0, '0, '0);
								n  = 2'd2;
							end else if (cur.link_state != hsc_pkg::LINK_SELECTED) begin
								r0.out_status = sel_status;
							end
						end
						hsc_pkg::ST_SELECT_RSP: begin
							if (cur.link_state == hsc_pkg::LINK_NOT_SELECTED) begin
								nxt.link_state = hsc_pkg::LINK_SELECTED;
								nxt.t7_running = 1'b0;
								r0 = hsc_pkg::make_res(hsc_pkg::ACT_NOTIFY, '0, '0, '0, '0, '0);
								r1 = hsc_pkg::make_res(hsc_pkg::ACT_RETIRE, '0, '0, '0, '0,
									item.system_bytes);
								n  = 2'd2;
							end else if (cur.link_state == hsc_pkg::LINK_SELECTED) begin
								r0 = hsc_pkg::make_res(hsc_pkg::ACT_RETIRE, '0, '0, '0, '0,
									item.system_bytes);
								n  = 2'd1;
							end
						end
						hsc_pkg::ST_DESEL_REQ: begin
							r0 = hsc_pkg::make_res(hsc_pkg::ACT_SEND, item.session_id, '0,
								hsc_pkg::STAT_NOT_ESTAB, hsc_pkg::ST_DESEL_RSP,
								item.system_bytes);
							n  = 2'd1;
							if (cur.link_state == hsc_pkg::LINK_SELECTED) begin
								nxt.link_state   = hsc_pkg::LINK_NOT_SELECTED;
								nxt.t7_running   = 1'b1;
								nxt.t7_remaining = cfg.t7_limit_ms;
								r0.out_status    = hsc_pkg::STAT_OK;
							end
						end
						hsc_pkg::ST_DESEL_RSP: begin
							if (cur.link_state != hsc_pkg::LINK_DOWN) begin
								nxt.link_state   = hsc_pkg::LINK_NOT_SELECTED;
								nxt.t7_running   = 1'b1;
								nxt.t7_remaining = cfg.t7_limit_ms;
							end
							r0 = hsc_pkg::make_res(hsc_pkg::ACT_RETIRE, '0, '0, '0, '0,
								item.system_bytes);
							n  = 2'd1;
						end
						hsc_pkg::ST_LINK_REQ: begin
							r0 = hsc_pkg::make_res(hsc_pkg::ACT_SEND, hsc_pkg::ALL_SESSIONS,
								'0, '0, hsc_pkg::ST_LINK_RSP, item.system_bytes);
							n  = 2'd1;
						end
						hsc_pkg::ST_LINK_RSP: begin
							r0 = hsc_pkg::make_res(hsc_pkg::ACT_RETIRE, '0, '0, '0, '0,
								item.system_bytes);
							n  = 2'd1;
							nxt.missed_linktests = 2'd0;
						end
						hsc_pkg::ST_REJECT, hsc_pkg::ST_SEPARATE: begin
							n = 2'd0;
						end
						default: begin
							r0 = rej_res;
							n  = 2'd1;
						end
					endcase
				end
			end
			hsc_pkg::CMD_CONNECTED: begin
				nxt.link_state       = hsc_pkg::LINK_NOT_SELECTED;
				nxt.idle_time        = '0;
				nxt.missed_linktests = 2'd0;
				nxt.t7_running       = 1'b0;
				nxt.t7_remaining     = '0;
				if (!cfg.gateway_mode) begin
					nxt.t7_running   = 1'b1;
					nxt.t7_remaining = cfg.t7_limit_ms;
					if (cfg.active_mode) begin
						r0 = hsc_pkg::make_res(hsc_pkg::ACT_SEND,
							cfg.gs_mode ? cfg.device_id : hsc_pkg::ALL_SESSIONS, '0, '0,
							hsc_pkg::ST_SELECT_REQ, '0);
						n  = 2'd1;
					end
				end
			end
			hsc_pkg::CMD_TIMEOUT: begin
				if (cur.link_state != hsc_pkg::LINK_DOWN) begin
					nxt.idle_time = idle_sat;
					if (idle_sat >= cfg.link_check_ms) begin
						nxt.idle_time = '0;
						if (cur.missed_linktests >= 2'd2) begin
							nxt.link_state   = hsc_pkg::LINK_DOWN;
							nxt.t7_running   = 1'b0;
							nxt.t7_remaining = '0;
							r0 = hsc_pkg::make_res(hsc_pkg::ACT_CLOSE, '0, '0, '0, '0, '0);
						end else begin
							r0 = hsc_pkg::make_res(hsc_pkg::ACT_SEND, hsc_pkg::ALL_SESSIONS,
								'0, '0, hsc_pkg::ST_LINK_REQ, '0);
							nxt.missed_linktests = cur.missed_linktests + 2'd1;
						end
						n = 2'd1;
					end
				end
			end
			hsc_pkg::CMD_TICK: begin
				if ((cur.link_state != hsc_pkg::LINK_DOWN) && cur.t7_running) begin
					if (cur.t7_remaining <= 18'd1) begin
						nxt.link_state   = hsc_pkg::LINK_DOWN;
						nxt.t7_running   = 1'b0;
						nxt.t7_remaining = '0;
						r0 = hsc_pkg::make_res(hsc_pkg::ACT_CLOSE, '0, '0, '0, '0, '0);
						n  = 2'd1;
					end else begin
						nxt.t7_remaining = cur.t7_remaining - 18'd1;
					end
				end
			end
			hsc_pkg::CMD_CLOSED: begin
				if (cur.link_state != hsc_pkg::LINK_DOWN) begin
					nxt.link_state   = hsc_pkg::LINK_DOWN;
					nxt.t7_running   = 1'b0;
					nxt.t7_remaining = '0;
					r0 = hsc_pkg::make_res(hsc_pkg::ACT_CLOSE, '0, '0, '0, '0, '0);
					n  = 2'd1;
				end
			end
			default: begin
				n = 2'd0;
			end
		endcase
		// An event that causes nothing still reports one beat.
		if (n == 2'd0) begin
			r0 = hsc_pkg::make_res(hsc_pkg::ACT_NONE, '0, '0, '0, '0, '0);
			n  = 2'd1;
		end
		r0.session_state = nxt.link_state;
		r1.session_state = nxt.link_state;
		r0.last          = (n == 2'd1);
		r1.last          = 1'b1;
	end

	assign pair.count  = n;
	assign pair.first  = r0;
	assign pair.second = r1;

endmodule

/* rtl/hsc_outbuf.sv */
// ----------------------------------------------------------------------------
// hsc_outbuf: two-entry result register
// Holds the results of one event and presents them one beat at a time.
// ----------------------------------------------------------------------------
module hsc_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  hsc_pkg::pair_t   pair,
	output logic             free,
	output logic             result_valid,
	input  logic             result_stall,
	output hsc_pkg::result_t result
);

	logic [1:0]       cnt_q;
	hsc_pkg::result_t head_q;
	hsc_pkg::result_t tail_q;
	logic             take;

	assign take         = (cnt_q != 2'd0) && !result_stall;
	// New results may enter once the last waiting beat leaves.
	assign free         = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !result_stall);
	assign result_valid = (cnt_q != 2'd0);
	assign result       = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= pair.count;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= pair.first;
			tail_q <= pair.second;
		end else if (take) begin
			head_q <= tail_q;
		end
	end

endmodule

/* rtl/hsms_session_control_top.sv */
// ----------------------------------------------------------------------------
// hsms_session_control_top: HSMS session state machine
// Events in, control replies and link actions out.
// ----------------------------------------------------------------------------
// Events enter on the item channel (item_valid, item_stall, item) and are
// taken at an edge where item_valid is high and item_stall is low. Each event
// produces one or two beats on the result channel (result_valid,
// result_stall, result); the final beat of an event has last set.
// A taken event sits in the input register until the result register is
// free; the session logic then writes its results into that two-entry
// register, which presents them on the result channel. Throughput: one event
// per cycle when each event yields one result and the receiver does not
// stall; after an event that yields two, the single result port keeps the
// next event in the input register until the second beat goes.
// While the receiver stalls, the results wait in the result register, the
// event behind them waits in the input register, and item_stall rises.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while no event is in flight. Writes to an
// index beyond the register list are ignored.
// Reset clears the session to not connected and loads the register defaults.
// ----------------------------------------------------------------------------
module hsms_session_control_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  hsc_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output hsc_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [2:0]                      cfg_index,
	input  logic [hsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic           valid_s1;
	hsc_pkg::item_t item_s1;
	hsc_pkg::cfg_t  cfg_q;
	hsc_pkg::sess_t sess_q;
	hsc_pkg::sess_t sess_nxt;
	hsc_pkg::pair_t pair;
	logic           buf_free;
	logic           advance;
	logic           accept;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && buf_free;
	assign item_stall = valid_s1 && !buf_free;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_id     <= '0;
			cfg_q.active_mode   <= 1'b0;
			cfg_q.gateway_mode  <= 1'b0;
			cfg_q.gs_mode       <= 1'b0;
			cfg_q.t7_limit_ms   <= hsc_pkg::T7_RESET;
			cfg_q.t8_period_ms  <= hsc_pkg::T8_RESET;
			cfg_q.link_check_ms <= hsc_pkg::LINK_CHECK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hsc_pkg::REG_DEVICE_ID:  cfg_q.device_id     <= cfg_data[15:0];
				hsc_pkg::REG_ACTIVE:     cfg_q.active_mode   <= cfg_data[0];
				hsc_pkg::REG_GATEWAY:    cfg_q.gateway_mode  <= cfg_data[0];
				hsc_pkg::REG_GS:         cfg_q.gs_mode       <= cfg_data[0];
				hsc_pkg::REG_T7_LIMIT:   cfg_q.t7_limit_ms   <= cfg_data[17:0];
				hsc_pkg::REG_T8_PERIOD:  cfg_q.t8_period_ms  <= cfg_data[16:0];
				hsc_pkg::REG_LINK_CHECK: cfg_q.link_check_ms <= cfg_data[17:0];
				default: begin
				end
			endcase
		end
	end

	// Session record moves only when an event leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_q <= '0;
		end else if (advance) begin
			sess_q <= sess_nxt;
		end
	end

	hsc_step u_step (
		.item (item_s1),
		.cur  (sess_q),
		.cfg  (cfg_q),
		.nxt  (sess_nxt),
		.pair (pair)
	);

	hsc_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.pair         (pair),
		.free         (buf_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
